/* hdl/fresnel_reflectance_macros.svh */
// Assertion macros used by the Fresnel reflectance RTL.
`ifndef FRESNEL_REFLECTANCE_MACROS_SVH
`define FRESNEL_REFLECTANCE_MACROS_SVH

// Same-cycle implication, checked on i_clk and disabled while i_rst_n is low.
`define FRR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk and disabled while i_rst_n is low.
`define FRR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/frr_pkg.sv */
// Package with the widths, constants and types of the Fresnel reflectance pipeline.
package frr_pkg;

    localparam int FRAC_BITS = 16;
    localparam int IN_W      = FRAC_BITS + 2;
    localparam int C_W       = FRAC_BITS + 1;
    localparam int N_W       = FRAC_BITS + 2;
    localparam int OUT_W     = FRAC_BITS + 1;
    localparam int NN_W      = 2 * N_W;
    localparam int CC_W      = 2 * C_W - 1;
    localparam int RAD_W     = NN_W;
    localparam int G_W       = N_W;
    localparam int GPC_W     = G_W + 1;
    localparam int CG_W      = C_W + G_W;
    localparam int T_W       = GPC_W;
    localparam int SQ_W      = 2 * GPC_W;
    localparam int T1_W      = FRAC_BITS - 1;
    localparam int Q_W       = 2 * FRAC_BITS;
    localparam int REM_W     = SQ_W + 1;
    localparam int PROD_W    = T1_W + Q_W + 1;

    localparam logic [C_W-1:0] ONE         = C_W'(1) << FRAC_BITS;
    localparam logic [N_W-1:0] RATIO_RESET = N_W'(87163);

    typedef enum logic [1:0] {
        CODE_BACK    = 2'd0,
        CODE_FULL    = 2'd1,
        CODE_FORMULA = 2'd2
    } t_code;

    // Side information that travels with each item down the pipeline.
    typedef struct packed {
        logic            valid;
        t_code           code;
        logic            big;
        logic [C_W-1:0]  c;
        logic [CC_W-1:0] cc;
    } t_tag;

endpackage

/* hdl/frr_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
module frr_sqrt
    import frr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [RAD_W-1:0] i_rad,
    input  t_tag             i_tag,
    output logic [G_W-1:0]   o_root,
    output t_tag             o_tag
);

    logic [RAD_W:0] r_rem  [1:G_W];
    logic [G_W-1:0] r_root [1:G_W];
    t_tag           r_tag  [1:G_W];

    for (genvar k = 0; k < G_W; k++) begin : g_stage
        localparam int B = G_W - 1 - k;
        logic [RAD_W:0] rem_in;
        logic [G_W-1:0] root_in;
        t_tag           tag_in;
        logic [RAD_W:0] delta;

        if (k == 0) begin : g_first
            assign rem_in  = {1'b0, i_rad};
            assign root_in = '0;
            assign tag_in  = i_tag;
        end else begin : g_rest
            assign rem_in  = r_rem[k];
            assign root_in = r_root[k];
            assign tag_in  = r_tag[k];
        end

        // (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B)
        assign delta = ((RAD_W+1)'(root_in) << (B + 1)) + ((RAD_W+1)'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[k+1].valid <= 1'b0;
            end else begin
                r_tag[k+1] <= tag_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (rem_in >= delta) begin
                r_rem[k+1]  <= rem_in - delta;
                r_root[k+1] <= root_in | (G_W'(1) << B);
            end else begin
                r_rem[k+1]  <= rem_in;
                r_root[k+1] <= root_in;
            end
        end
    end

    assign o_root = r_root[G_W];
    assign o_tag  = r_tag[G_W];

endmodule

/* hdl/frr_div.sv */
// Two restoring dividers side by side, one quotient bit per stage; the T1 divider holds after T1_W stages.
module frr_div
    import frr_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [SQ_W-1:0] i_t1_num,
    input  logic [SQ_W-1:0] i_t1_den,
    input  logic [SQ_W-1:0] i_q_num,
    input  logic [SQ_W-1:0] i_q_den,
    input  t_tag            i_tag,
    output logic [T1_W-1:0] o_t1,
    output logic [Q_W-1:0]  o_q,
    output t_tag            o_tag
);

    logic [REM_W-1:0]     r_qrem [1:Q_W];
    logic [FRAC_BITS-1:0] r_qlo  [1:Q_W];
    logic [Q_W-1:0]       r_q    [1:Q_W];
    logic [SQ_W-1:0]      r_qden [1:Q_W];
    logic [REM_W-1:0]     r_trem [1:Q_W];
    logic [T1_W-1:0]      r_t1   [1:Q_W];
    logic [SQ_W-1:0]      r_tden [1:Q_W];
    t_tag                 r_tag  [1:Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic [REM_W-1:0]     qrem_in;
        logic [FRAC_BITS-1:0] qlo_in;
        logic [Q_W-1:0]       q_in;
        logic [SQ_W-1:0]      qden_in;
        logic [REM_W-1:0]     trem_in;
        logic [T1_W-1:0]      t1_in;
        logic [SQ_W-1:0]      tden_in;
        t_tag                 tag_in;
        logic [REM_W-1:0]     qsh;
        logic [REM_W-1:0]     tsh;

        if (k == 0) begin : g_first
            // The quotient is known to stay below 2^Q_W here (larger ones are
            // flagged as big upstream), so the upper numerator bits start the remainder.
            assign qrem_in = REM_W'(i_q_num >> FRAC_BITS);
            assign qlo_in  = i_q_num[FRAC_BITS-1:0];
            assign q_in    = '0;
            assign qden_in = i_q_den;
            assign trem_in = REM_W'(i_t1_num);
            assign t1_in   = '0;
            assign tden_in = i_t1_den;
            assign tag_in  = i_tag;
        end else begin : g_rest
            assign qrem_in = r_qrem[k];
            assign qlo_in  = r_qlo[k];
            assign q_in    = r_q[k];
            assign qden_in = r_qden[k];
            assign trem_in = r_trem[k];
            assign t1_in   = r_t1[k];
            assign tden_in = r_tden[k];
            assign tag_in  = r_tag[k];
        end

        assign qsh = {qrem_in[REM_W-2:0], qlo_in[FRAC_BITS-1]};
        assign tsh = {trem_in[REM_W-2:0], 1'b0};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[k+1].valid <= 1'b0;
            end else begin
                r_tag[k+1] <= tag_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_qden[k+1] <= qden_in;
            r_tden[k+1] <= tden_in;
            r_qlo[k+1]  <= {qlo_in[FRAC_BITS-2:0], 1'b0};
            if (qsh >= {1'b0, qden_in}) begin
                r_qrem[k+1] <= qsh - {1'b0, qden_in};
                r_q[k+1]    <= {q_in[Q_W-2:0], 1'b1};
            end else begin
                r_qrem[k+1] <= qsh;
                r_q[k+1]    <= {q_in[Q_W-2:0], 1'b0};
            end
        end

        if (k < T1_W) begin : g_t1_step
            always_ff @(posedge i_clk) begin
                if (tsh >= {1'b0, tden_in}) begin
                    r_trem[k+1] <= tsh - {1'b0, tden_in};
                    r_t1[k+1]   <= {t1_in[T1_W-2:0], 1'b1};
                end else begin
                    r_trem[k+1] <= tsh;
                    r_t1[k+1]   <= {t1_in[T1_W-2:0], 1'b0};
                end
            end
        end else begin : g_t1_hold
            always_ff @(posedge i_clk) begin
                r_trem[k+1] <= trem_in;
                r_t1[k+1]   <= t1_in;
            end
        end
    end

    assign o_t1  = r_t1[Q_W];
    assign o_q   = r_q[Q_W];
    assign o_tag = r_tag[Q_W];

endmodule

/* hdl/fresnel_reflectance.sv */
// Top level of the pipelined unpolarized Fresnel reflectance unit.
//
//  Channel   Direction  Handshake                    Payload
//  -------   ---------  ---------------------------  ------------------------------
//  command   in         start, busy                  i_cos_angle (signed Q1.16)
//  result    out        o_result_valid (strobe)      o_reflectance, o_case_code
//  config    in         i_cfg_we                     i_cfg_wdata (ratio, Q2.16)
//
// The unit is a fixed pipeline of 59 register stages and takes one transaction in
// every cycle, so busy is always low. The result of a transaction is loaded into the
// output register in order and stays for exactly one cycle with o_result_valid high.
// The length is set by the 18-stage square root and the 32-stage divider.
// The receiver cannot stall, so nothing ever holds in the pipeline.
// Reset is synchronous and active low; it clears every valid bit and sets the
// refraction ratio to 1.33.

`include "fresnel_reflectance_macros.svh"

module fresnel_reflectance
    import frr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [IN_W-1:0]  i_cos_angle,
    output logic             o_result_valid,
    output logic [OUT_W-1:0] o_reflectance,
    output logic [1:0]       o_case_code,
    input  logic             i_cfg_we,
    input  logic [N_W-1:0]   i_cfg_wdata
);

    localparam logic [NN_W:0] ONE_SQ = (NN_W+1)'(1) << (2 * FRAC_BITS);

    logic [N_W-1:0] r_ratio;

    // Stage 1: clamp the cosine and sort out the trivial cases.
    t_tag           r_s1_tag;
    t_tag           n_s1_tag;
    logic [N_W-1:0] r_s1_n;
    logic [C_W-1:0] w_c_mag;

    // Stage 2: squares of the ratio and of the cosine.
    t_tag            r_s2_tag;
    t_tag            n_s2_tag;
    logic [NN_W-1:0] r_s2_nn;

    // Stage 3: radicand and the total reflection test.
    t_tag             r_s3_tag;
    t_tag             n_s3_tag;
    logic [RAD_W-1:0] r_s3_rad;
    logic [NN_W:0]    w_sum;

    // Square root output.
    logic [G_W-1:0] w_g;
    t_tag           w_sq_tag;

    // Stage 4: G + c, |G - c| and c*G.
    t_tag            r_s4_tag;
    logic [GPC_W-1:0] r_s4_gpc;
    logic [G_W-1:0]  r_s4_gmc;
    logic [CG_W-1:0] r_s4_cg;
    logic [G_W-1:0]  w_c_ext;

    // Stage 5: first squares and the second pair of terms.
    t_tag            r_s5_tag;
    logic [SQ_W-1:0] r_s5_gmc2;
    logic [SQ_W-1:0] r_s5_gpc2;
    logic [T_W-1:0]  r_s5_t2m;
    logic [T_W-1:0]  r_s5_t3;
    logic [CG_W-1:0] w_s;
    logic [CG_W-1:0] w_s_diff;
    logic [CG_W:0]   w_t3_full;

    // Stage 6: second squares.
    t_tag            r_s6_tag;
    logic [SQ_W-1:0] r_s6_gmc2;
    logic [SQ_W-1:0] r_s6_gpc2;
    logic [SQ_W-1:0] r_s6_qnum;
    logic [SQ_W-1:0] r_s6_qden;

    // Stage 7: quotient range check ahead of the divider.
    t_tag            r_s7_tag;
    t_tag            n_s7_tag;
    logic [SQ_W-1:0] r_s7_gmc2;
    logic [SQ_W-1:0] r_s7_gpc2;
    logic [SQ_W-1:0] r_s7_qnum;
    logic [SQ_W-1:0] r_s7_qden;

    // Divider output.
    logic [T1_W-1:0] w_t1;
    logic [Q_W-1:0]  w_q;
    t_tag            w_dv_tag;

    // Stage 8: final product.
    t_tag              r_s8_tag;
    logic [PROD_W-1:0] r_s8_prod;
    logic              r_s8_t1nz;
    logic [Q_W:0]      w_one_plus_q;

    // Stage 9: result register.
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_refl;
    t_code            r_out_code;
    logic [OUT_W-1:0] n_out_refl;
    logic             w_sat;

    // Every stage advances every cycle, so a transaction is always taken.
    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio <= RATIO_RESET;
        end else if (i_cfg_we) begin
            r_ratio <= i_cfg_wdata;
        end
    end

    // Stage 1.
    assign w_c_mag = (i_cos_angle[C_W-1:0] > ONE) ? ONE : i_cos_angle[C_W-1:0];

    always_comb begin
        n_s1_tag       = '0;
        n_s1_tag.valid = start && !busy;
        n_s1_tag.c     = w_c_mag;
        if (i_cos_angle[IN_W-1]) begin
            n_s1_tag.code = CODE_BACK;
        end else if (w_c_mag == '0) begin
            n_s1_tag.code = CODE_FULL;
        end else begin
            n_s1_tag.code = CODE_FORMULA;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_tag.valid <= 1'b0;
        end else begin
            r_s1_tag <= n_s1_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_n <= r_ratio;
    end

    // Stage 2.
    always_comb begin
        n_s2_tag    = r_s1_tag;
        n_s2_tag.cc = CC_W'(r_s1_tag.c * r_s1_tag.c);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_tag.valid <= 1'b0;
        end else begin
            r_s2_tag <= n_s2_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_nn <= NN_W'(r_s1_n * r_s1_n);
    end

    // Stage 3: a radicand below zero means total reflection.
    assign w_sum = (NN_W+1)'(r_s2_nn) + (NN_W+1)'(r_s2_tag.cc);

    always_comb begin
        n_s3_tag = r_s2_tag;
        if (r_s2_tag.code == CODE_FORMULA && w_sum < ONE_SQ) begin
            n_s3_tag.code = CODE_FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_tag.valid <= 1'b0;
        end else begin
            r_s3_tag <= n_s3_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_rad <= RAD_W'(w_sum - ONE_SQ);
    end

    frr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rad   (r_s3_rad),
        .i_tag   (r_s3_tag),
        .o_root  (w_g),
        .o_tag   (w_sq_tag)
    );

    // Stage 4.
    assign w_c_ext = G_W'(w_sq_tag.c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_tag.valid <= 1'b0;
        end else begin
            r_s4_tag <= w_sq_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_gpc <= GPC_W'(w_g) + GPC_W'(w_sq_tag.c);
        r_s4_gmc <= (w_g >= w_c_ext) ? (w_g - w_c_ext) : (w_c_ext - w_g);
        r_s4_cg  <= CG_W'(w_sq_tag.c * w_g);
    end

    // Stage 5: c(G+c) = cG + c^2, and c(G-c) + 1 = 1 - c^2 + cG.
    assign w_s       = r_s4_cg + CG_W'(r_s4_tag.cc);
    assign w_s_diff  = (w_s >= CG_W'(ONE_SQ)) ? (w_s - CG_W'(ONE_SQ))
                                              : (CG_W'(ONE_SQ) - w_s);
    assign w_t3_full = (CG_W+1)'(ONE_SQ) + (CG_W+1)'(r_s4_cg) - (CG_W+1)'(r_s4_tag.cc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_tag.valid <= 1'b0;
        end else begin
            r_s5_tag <= r_s4_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s5_gmc2 <= SQ_W'(r_s4_gmc * r_s4_gmc);
        r_s5_gpc2 <= SQ_W'(r_s4_gpc * r_s4_gpc);
        r_s5_t2m  <= T_W'(w_s_diff >> FRAC_BITS);
        r_s5_t3   <= T_W'(w_t3_full >> FRAC_BITS);
    end

    // Stage 6.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_tag.valid <= 1'b0;
        end else begin
            r_s6_tag <= r_s5_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s6_gmc2 <= r_s5_gmc2;
        r_s6_gpc2 <= r_s5_gpc2;
        r_s6_qnum <= SQ_W'(r_s5_t2m * r_s5_t2m);
        r_s6_qden <= SQ_W'(r_s5_t3 * r_s5_t3);
    end

    // Stage 7: a quotient of 2^(2F) or more, or a zero denominator, saturates the
    // result unless T1 is zero, so the divider only has to produce the low bits.
    always_comb begin
        n_s7_tag     = r_s6_tag;
        n_s7_tag.big = {{FRAC_BITS{1'b0}}, r_s6_qnum} >= {r_s6_qden, {FRAC_BITS{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_tag.valid <= 1'b0;
        end else begin
            r_s7_tag <= n_s7_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s7_gmc2 <= r_s6_gmc2;
        r_s7_gpc2 <= r_s6_gpc2;
        r_s7_qnum <= r_s6_qnum;
        r_s7_qden <= r_s6_qden;
    end

    frr_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_t1_num (r_s7_gmc2),
        .i_t1_den (r_s7_gpc2),
        .i_q_num  (r_s7_qnum),
        .i_q_den  (r_s7_qden),
        .i_tag    (r_s7_tag),
        .o_t1     (w_t1),
        .o_q      (w_q),
        .o_tag    (w_dv_tag)
    );

    // Stage 8: T1 * (1 + Q), with T1 in F-1 and Q in F fraction bits.
    assign w_one_plus_q = (Q_W+1)'(w_q) + ((Q_W+1)'(1) << FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s8_tag.valid <= 1'b0;
        end else begin
            r_s8_tag <= w_dv_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s8_prod <= PROD_W'(w_t1 * w_one_plus_q);
        r_s8_t1nz <= (w_t1 != '0);
    end

    // Stage 9: saturate at 1.0 and pick the value by case.
    assign w_sat = (r_s8_t1nz && r_s8_tag.big) || (r_s8_prod[PROD_W-1:Q_W] != '0);

    always_comb begin
        case (r_s8_tag.code)
            CODE_BACK:    n_out_refl = '0;
            CODE_FULL:    n_out_refl = ONE;
            CODE_FORMULA: n_out_refl = w_sat ? ONE : {1'b0, r_s8_prod[Q_W-1:FRAC_BITS]};
            default:      n_out_refl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_s8_tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_refl <= n_out_refl;
        r_out_code <= r_s8_tag.code;
    end

    assign o_result_valid = r_out_valid;
    assign o_reflectance  = r_out_refl;
    assign o_case_code    = r_out_code;

    // A back-facing result is always zero, and a forced one is always 1.0.
    `FRR_ASSERT_NOW(a_back_zero, o_result_valid && o_case_code == CODE_BACK, o_reflectance == '0, "back-facing result is not zero")
    `FRR_ASSERT_NOW(a_full_one, o_result_valid && o_case_code == CODE_FULL, o_reflectance == ONE, "forced reflection is not 1.0")
    `FRR_ASSERT_NOW(a_refl_range, o_result_valid, o_reflectance <= ONE, "reflectance above 1.0")
    `FRR_ASSERT_NEXT(a_neg_classified, start && !busy && i_cos_angle[IN_W-1], r_s1_tag.valid && r_s1_tag.code == CODE_BACK, "negative cosine not marked back facing")

endmodule

/* dv/tb_fresnel_reflectance.sv */
// Self-checking testbench for the pipelined Fresnel reflectance unit.
module tb_fresnel_reflectance;
    import frr_pkg::*;

    localparam int LATENCY   = 59;
    localparam int MAX_CYCLE = 400000;

    logic             i_clk;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [IN_W-1:0]  i_cos_angle;
    logic             o_result_valid;
    logic [OUT_W-1:0] o_reflectance;
    logic [1:0]       o_case_code;
    logic             i_cfg_we = 1'b0;
    logic [N_W-1:0]   i_cfg_wdata;

    fresnel_reflectance dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cos_angle    (i_cos_angle),
        .o_result_valid (o_result_valid),
        .o_reflectance  (o_reflectance),
        .o_case_code    (o_case_code),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    typedef struct packed {
        logic [OUT_W-1:0] refl;
        t_code            code;
    } t_refl_result;

    // Stimulus entries: either an angle command or a ratio write. A ratio
    // write is only issued once the pipeline has drained.
    typedef struct packed {
        logic            is_cfg;
        logic            drain;
        logic [N_W-1:0]  value;
    } t_stim;

    t_stim            stim_q[$];
    t_refl_result     expected_q[$];
    logic [N_W-1:0]   ratio_model;
    int               cycle_cnt = 0;
    int               gap_left;
    int               settle_left;
    bit               stim_done = 1'b0;
    bit               failed = 1'b0;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Exact integer square root by restoring bit pairs.
    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Fixed-point quotient num * 2^fb / den, clamped at 2^62.
    function automatic logic [63:0] frac_quotient(input logic [63:0] num,
                                                  input logic [63:0] den, input int fb);
        logic [63:0] cap;
        logic [63:0] q;
        logic [63:0] rem;
        cap = 64'd1 << 62;
        if (den == 0) return cap;
        q   = num / den;
        rem = num % den;
        if (q > cap) return cap;
        for (int i = 0; i < fb; i++) begin
            if (q > (cap >> 1)) return cap;
            q   = q << 1;
            rem = rem << 1;
            if (rem >= den) begin
                rem = rem - den;
                q   = q | 64'd1;
            end
        end
        return (q > cap) ? cap : q;
    endfunction

    function automatic t_refl_result fresnel_predict(input logic [IN_W-1:0] cos_in,
                                                     input logic [N_W-1:0] ratio);
        t_refl_result r;
        logic [63:0]  one, one2, c, n, rad, g, gpc, gmc, t1, s, t2m, t3, q, lim, refl;
        one  = 64'd1 << FRAC_BITS;
        one2 = one * one;
        if (cos_in[IN_W-1]) begin
            // Back-facing surface sees no reflection.
            r.refl = '0;
            r.code = CODE_BACK;
            return r;
        end
        c = (64'(cos_in) > one) ? one : 64'(cos_in);
        n = 64'(ratio);
        if (c == 0 || n * n + c * c < one2) begin
            // Grazing incidence or total internal reflection.
            r.refl = OUT_W'(one);
            r.code = CODE_FULL;
            return r;
        end
        rad = n * n + c * c - one2;
        g   = root_floor(rad);
        gpc = g + c;
        gmc = (g >= c) ? g - c : c - g;
        t1  = frac_quotient(gmc * gmc, gpc * gpc, FRAC_BITS - 1);
        s   = c * gpc;
        t2m = ((s >= one2) ? s - one2 : one2 - s) >> FRAC_BITS;
        t3  = (one2 - c * c + c * g) >> FRAC_BITS;
        q   = frac_quotient(t2m * t2m, t3 * t3, FRAC_BITS);
        s   = one + q;
        if (t1 == 0) begin
            refl = 0;
        end else begin
            // Compare against the saturation point before multiplying.
            lim  = ((one << FRAC_BITS) + t1 - 1) / t1;
            refl = (s >= lim) ? one : (t1 * s) >> FRAC_BITS;
        end
        if (refl > one) refl = one;
        r.refl = OUT_W'(refl);
        r.code = CODE_FORMULA;
        return r;
    endfunction

    function automatic t_stim angle_item(input logic [IN_W-1:0] a);
        t_stim t;
        t.is_cfg = 1'b0;
        t.drain  = 1'b0;
        t.value  = a;
        return t;
    endfunction

    function automatic t_stim ratio_item(input logic [N_W-1:0] v);
        t_stim t;
        t.is_cfg = 1'b1;
        t.drain  = 1'b1;
        t.value  = v;
        return t;
    endfunction

    // Random angle: mostly legal cosines, some negative, some raw bits.
    function automatic logic [IN_W-1:0] random_angle();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) return IN_W'($urandom_range(0, 65536));
        if (sel < 8) return IN_W'(-$signed($urandom_range(1, 65536)));
        return IN_W'($urandom);
    endfunction

    initial begin
        logic [N_W-1:0] ratios[6];
        t_stim          pause;
        ratios = '{N_W'(65536), N_W'(0), N_W'(262143), N_W'(98304), N_W'(65535),
                   N_W'(87163)};

        // Directed part at the reset ratio: field extremes and every case.
        stim_q.push_back(angle_item(IN_W'(0)));
        stim_q.push_back(angle_item(IN_W'(65536)));
        stim_q.push_back(angle_item(IN_W'(65537)));
        stim_q.push_back(angle_item(IN_W'(131071)));
        stim_q.push_back(angle_item(IN_W'(-1)));
        stim_q.push_back(angle_item(IN_W'(-65536)));
        stim_q.push_back(angle_item(IN_W'(131072)));
        stim_q.push_back(angle_item(IN_W'(1)));
        stim_q.push_back(angle_item(IN_W'(32768)));
        stim_q.push_back(angle_item(IN_W'(50393)));
        // Zero ratio gives total reflection, except at normal incidence where
        // the second denominator vanishes and the result saturates.
        stim_q.push_back(ratio_item(N_W'(0)));
        stim_q.push_back(angle_item(IN_W'(65536)));
        stim_q.push_back(angle_item(IN_W'(70000)));
        stim_q.push_back(angle_item(IN_W'(40000)));
        stim_q.push_back(ratio_item(N_W'(262143)));
        stim_q.push_back(angle_item(IN_W'(1)));
        stim_q.push_back(angle_item(IN_W'(65536)));
        stim_q.push_back(ratio_item(N_W'(40000)));
        stim_q.push_back(angle_item(IN_W'(65536)));
        stim_q.push_back(angle_item(IN_W'(20000)));

        for (int ph = 0; ph < 12; ph++) begin
            if (ph < 6) stim_q.push_back(ratio_item(ratios[ph]));
            else stim_q.push_back(ratio_item(N_W'($urandom_range(0, 262143))));
            for (int k = 0; k < 155; k++) begin
                stim_q.push_back(angle_item(random_angle()));
                // Occasionally let the pipeline run dry before continuing.
                if (k == 80) begin
                    pause       = angle_item('0);
                    pause.drain = 1'b1;
                    stim_q.push_back(pause);
                end
            end
        end
    end

    // Driver: issues commands with random gaps and holds off ratio writes or
    // drain points until every expected result has been collected.
    always @(posedge i_clk) begin
        t_stim head;
        logic  nx_start;
        logic  nx_we;
        nx_start = 1'b0;
        nx_we    = 1'b0;
        cycle_cnt <= cycle_cnt + 1;
        if (!i_rst_n) begin
            gap_left    <= 0;
            settle_left <= 0;
        end else if (start && busy) begin
            // Command not taken yet; keep it on the bus.
            nx_start = 1'b1;
        end else if (stim_q.size() == 0) begin
            stim_done <= 1'b1;
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
        end else begin
            head = stim_q[0];
            if (head.drain && expected_q.size() != 0) begin
                settle_left <= 4;
            end else if (head.drain && settle_left > 0) begin
                settle_left <= settle_left - 1;
            end else if (head.is_cfg) begin
                void'(stim_q.pop_front());
                nx_we        = 1'b1;
                i_cfg_wdata <= head.value;
                ratio_model <= head.value;
            end else if (head.drain) begin
                void'(stim_q.pop_front());
                head.drain = 1'b0;
                stim_q.push_front(head);
            end else begin
                void'(stim_q.pop_front());
                nx_start     = 1'b1;
                i_cos_angle <= IN_W'(head.value);
                expected_q.push_back(fresnel_predict(IN_W'(head.value), ratio_model));
                if ($urandom_range(0, 3) == 0) begin
                    gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80)
                                                           : $urandom_range(1, 3);
                end
            end
        end
        start    <= nx_start;
        i_cfg_we <= nx_we;
    end

    // Monitor: every strobed result must match the oldest prediction.
    always @(posedge i_clk) begin
        t_refl_result exp_r;
        if (i_rst_n && o_result_valid) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result refl=%0d code=%0d", $time,
                         o_reflectance, o_case_code);
                failed <= 1'b1;
            end else begin
                exp_r = expected_q.pop_front();
                if (o_reflectance !== exp_r.refl || o_case_code !== exp_r.code) begin
                    $display("%0t: mismatch expected refl=%0d code=%0d actual refl=%0d code=%0d",
                             $time, exp_r.refl, exp_r.code, o_reflectance, o_case_code);
                    failed <= 1'b1;
                end
            end
        end
    end

    initial begin
        start       = 1'b0;
        i_cos_angle = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        ratio_model = RATIO_RESET;
        cycle_cnt   = 0;
        stim_done   = 1'b0;
        failed      = 1'b0;
        i_rst_n     = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the stimulus to drain, bounded by the cycle limit.
        while (!(stim_done && expected_q.size() == 0) && cycle_cnt < MAX_CYCLE)
            @(posedge i_clk);
        if (cycle_cnt >= MAX_CYCLE) begin
            $display("fresnel_reflectance test failed");
        end else begin
            // Catch any stray result that arrives after the last expected one.
            repeat (LATENCY + 10) @(posedge i_clk);
            if (failed || expected_q.size() != 0) begin
                $display("fresnel_reflectance test failed");
            end else begin
                $display("fresnel_reflectance test passed");
            end
        end
        $finish;
    end

endmodule
